// ----- hdl/fls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fls_pkg
// Widths and defaults shared by the float literal scanner and its channels.
// ----------------------------------------------------------------------------
package fls_pkg;

	localparam int CHAR_W            = 8;
	localparam int LEN_W             = 7;
	localparam int VALUE_WIDTH       = 32;
	localparam int FRAC_W            = VALUE_WIDTH - 1;
	localparam int MAX_TOKEN_LEN_DEF = 64;

endpackage

// ----- hdl/fls_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fls_if
// Valid/ready channels of the float literal scanner: characters in, results out.
// ----------------------------------------------------------------------------
interface fls_char_if import fls_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              is_last;

	modport source(output valid, output char_code, output is_last, input ready);
	modport sink(input valid, input char_code, input is_last, output ready);

endinterface

interface fls_res_if import fls_pkg::*; ();

	logic                          valid;
	logic                          ready;
	logic                          valid_res;
	logic [LEN_W-1:0]              base_length;
	logic [LEN_W-1:0]              fraction_start;
	logic [LEN_W-1:0]              fraction_length;
	logic [LEN_W-1:0]              exponent_start;
	logic [LEN_W-1:0]              exponent_length;
	logic signed [VALUE_WIDTH-1:0] base_value;
	logic [FRAC_W-1:0]             fraction_value;
	logic signed [VALUE_WIDTH-1:0] exponent_value;
	logic                          overflow;

	modport source(output valid, output valid_res, output base_length,
		output fraction_start, output fraction_length, output exponent_start,
		output exponent_length, output base_value, output fraction_value,
		output exponent_value, output overflow, input ready);
	modport sink(input valid, input valid_res, input base_length,
		input fraction_start, input fraction_length, input exponent_start,
		input exponent_length, input base_value, input fraction_value,
		input exponent_value, input overflow, output ready);

endinterface

// ----- hdl/float_literal_scanner.sv -----
// A token's last character is held in the input register, then its result in the result register.
// Throughput: one character per cycle while no last character is held back; each
// character passes the combinational scan logic behind the input register.
// A last character waits in the input register only while a result is not taken.
// Reset (arst_n low, asynchronous) clears both stage valids and all scan state.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_literal_scanner
// Checks a token, one character a beat, against the decimal float form and
// reports part positions/lengths and the base, fraction and exponent values.
// ----------------------------------------------------------------------------
module float_literal_scanner import fls_pkg::*; #(
	parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
	input logic        clk,
	input logic        arst_n,
	fls_char_if.sink   chars,
	fls_res_if.source  result
);

	localparam int PW = $clog2(MAX_TOKEN_LEN + 1);
	localparam int MW = FRAC_W;
	localparam int XW = MW + 4;
	localparam logic [MW-1:0] MAG_LIMIT = '1;

	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_E_LO  = 8'h65;
	localparam logic [CHAR_W-1:0] CH_E_UP  = 8'h45;

	localparam logic [1:0] PART_BASE = 2'd0;
	localparam logic [1:0] PART_FRAC = 2'd1;
	localparam logic [1:0] PART_EXP  = 2'd2;

	// input stage
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              advance;
	logic              fire_s1;

	// scan state
	logic [PW-1:0] pos_q, base_len_q, frac_len_q, dot_pos_q, marker_pos_q;
	logic [1:0]    part_q;
	logic          seen_dot_q, seen_marker_q, rejected_q;
	logic [MW-1:0] base_acc_q, frac_acc_q, exp_acc_q;
	logic          base_neg_q, exp_neg_q, ovf_q, base_signed_q, exp_signed_q;

	logic [PW-1:0] pos_n, base_len_n, frac_len_n, dot_pos_n, marker_pos_n;
	logic [1:0]    part_n;
	logic          seen_dot_n, seen_marker_n, rejected_n;
	logic [MW-1:0] base_acc_n, frac_acc_n, exp_acc_n;
	logic          base_neg_n, exp_neg_n, ovf_n, base_signed_n, exp_signed_n;

	// digit path, shared by the three accumulators
	logic          is_digit, is_sign, is_marker, in_range;
	logic [3:0]    digit;
	logic [MW-1:0] acc_sel, acc_push;
	logic [XW-1:0] acc_wide;
	logic          acc_ovf;

	// final checks
	logic [PW-1:0] blen, flen, elen;
	logic          ok;

	// result register
	logic                          valid_s2;
	logic                          valid_res_s2;
	logic [LEN_W-1:0]              base_length_s2, fraction_start_s2, fraction_length_s2;
	logic [LEN_W-1:0]              exponent_start_s2, exponent_length_s2;
	logic signed [VALUE_WIDTH-1:0] base_value_s2, exponent_value_s2;
	logic [FRAC_W-1:0]             fraction_value_s2;
	logic                          overflow_s2;

	// a non-last character never needs the result register
	assign advance     = !last_s1 || !valid_s2 || result.ready;
	assign fire_s1     = valid_s1 && advance;
	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.is_last;
		end
	end

	assign is_digit  = (char_s1 >= CH_0) && (char_s1 <= CH_9);
	assign digit     = 4'(char_s1 - CH_0);
	assign is_sign   = (char_s1 == CH_PLUS) || (char_s1 == CH_MINUS);
	assign is_marker = (char_s1 == CH_E_LO) || (char_s1 == CH_E_UP);
	assign in_range  = pos_q < PW'(MAX_TOKEN_LEN);

	assign acc_sel = (part_q == PART_BASE) ? base_acc_q :
		(part_q == PART_FRAC) ? frac_acc_q : exp_acc_q;
	// acc*10 + d > limit is the same test as acc > (limit - d) / 10
	assign acc_wide = (XW'(acc_sel) << 3) + (XW'(acc_sel) << 1) + XW'(digit);
	assign acc_ovf  = acc_wide > XW'(MAG_LIMIT);
	assign acc_push = acc_ovf ? MAG_LIMIT : acc_wide[MW-1:0];

	always_comb begin
		pos_n         = pos_q;
		part_n        = part_q;
		seen_dot_n    = seen_dot_q;
		seen_marker_n = seen_marker_q;
		rejected_n    = rejected_q;
		base_len_n    = base_len_q;
		frac_len_n    = frac_len_q;
		dot_pos_n     = dot_pos_q;
		marker_pos_n  = marker_pos_q;
		base_acc_n    = base_acc_q;
		frac_acc_n    = frac_acc_q;
		exp_acc_n     = exp_acc_q;
		base_neg_n    = base_neg_q;
		exp_neg_n     = exp_neg_q;
		ovf_n         = ovf_q;
		base_signed_n = base_signed_q;
		exp_signed_n  = exp_signed_q;

		if (!in_range) begin
			rejected_n = 1'b1;
		end else begin
			pos_n = pos_q + PW'(1);
			if (!rejected_q) begin
				priority if (is_digit) begin
					ovf_n = ovf_q || acc_ovf;
					if (part_q == PART_BASE) begin
						base_acc_n = acc_push;
					end else if (part_q == PART_FRAC) begin
						frac_acc_n = acc_push;
					end else begin
						exp_acc_n = acc_push;
					end
				end else if (pos_q == '0 && is_sign) begin
					base_signed_n = 1'b1;
					base_neg_n    = (char_s1 == CH_MINUS);
				end else if (is_marker && !seen_marker_q) begin
					if (part_q == PART_BASE) begin
						base_len_n = pos_q;
					end else begin
						frac_len_n = pos_q - (dot_pos_q + PW'(1));
					end
					seen_marker_n = 1'b1;
					marker_pos_n  = pos_q;
					part_n        = PART_EXP;
				end else if (char_s1 == CH_DOT && !seen_dot_q && !seen_marker_q) begin
					base_len_n = pos_q;
					seen_dot_n = 1'b1;
					dot_pos_n  = pos_q;
					part_n     = PART_FRAC;
				end else if (seen_marker_q && pos_q == marker_pos_q + PW'(1) && is_sign) begin
					exp_signed_n = 1'b1;
					exp_neg_n    = (char_s1 == CH_MINUS);
				end else begin
					rejected_n = 1'b1;
				end
			end
		end
	end

	// close the open part and check the token as it stands after this character
	always_comb begin
		blen = base_len_n;
		flen = frac_len_n;
		elen = '0;
		if (part_n == PART_BASE) begin
			blen = pos_n;
		end else if (part_n == PART_FRAC) begin
			flen = pos_n - (dot_pos_n + PW'(1));
		end else begin
			elen = pos_n - (marker_pos_n + PW'(1));
		end

		ok = !rejected_n;
		if (blen == PW'(1) && base_signed_n) begin
			ok = 1'b0;
		end
		if (blen == '0 && flen == '0) begin
			ok = 1'b0;
		end
		if (seen_marker_n && (elen == '0 || (elen == PW'(1) && exp_signed_n))) begin
			ok = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			part_q        <= PART_BASE;
			seen_dot_q    <= 1'b0;
			seen_marker_q <= 1'b0;
			rejected_q    <= 1'b0;
			base_len_q    <= '0;
			frac_len_q    <= '0;
			dot_pos_q     <= '0;
			marker_pos_q  <= '0;
			base_acc_q    <= '0;
			frac_acc_q    <= '0;
			exp_acc_q     <= '0;
			base_neg_q    <= 1'b0;
			exp_neg_q     <= 1'b0;
			ovf_q         <= 1'b0;
			base_signed_q <= 1'b0;
			exp_signed_q  <= 1'b0;
		end else if (fire_s1) begin
			if (last_s1) begin
				pos_q         <= '0;
				part_q        <= PART_BASE;
				seen_dot_q    <= 1'b0;
				seen_marker_q <= 1'b0;
				rejected_q    <= 1'b0;
				base_len_q    <= '0;
				frac_len_q    <= '0;
				dot_pos_q     <= '0;
				marker_pos_q  <= '0;
				base_acc_q    <= '0;
				frac_acc_q    <= '0;
				exp_acc_q     <= '0;
				base_neg_q    <= 1'b0;
				exp_neg_q     <= 1'b0;
				ovf_q         <= 1'b0;
				base_signed_q <= 1'b0;
				exp_signed_q  <= 1'b0;
			end else begin
				pos_q         <= pos_n;
				part_q        <= part_n;
				seen_dot_q    <= seen_dot_n;
				seen_marker_q <= seen_marker_n;
				rejected_q    <= rejected_n;
				base_len_q    <= base_len_n;
				frac_len_q    <= frac_len_n;
				dot_pos_q     <= dot_pos_n;
				marker_pos_q  <= marker_pos_n;
				base_acc_q    <= base_acc_n;
				frac_acc_q    <= frac_acc_n;
				exp_acc_q     <= exp_acc_n;
				base_neg_q    <= base_neg_n;
				exp_neg_q     <= exp_neg_n;
				ovf_q         <= ovf_n;
				base_signed_q <= base_signed_n;
				exp_signed_q  <= exp_signed_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// a rejected token reports all fields as zero
	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			valid_res_s2       <= ok;
			base_length_s2     <= ok ? LEN_W'(blen) : '0;
			fraction_start_s2  <= (ok && seen_dot_n) ? LEN_W'(dot_pos_n + PW'(1)) : '0;
			fraction_length_s2 <= ok ? LEN_W'(flen) : '0;
			exponent_start_s2  <= (ok && seen_marker_n) ?
				LEN_W'(marker_pos_n + PW'(1)) : '0;
			exponent_length_s2 <= ok ? LEN_W'(elen) : '0;
			base_value_s2      <= !ok ? '0 :
				base_neg_n ? -$signed({1'b0, base_acc_n}) : $signed({1'b0, base_acc_n});
			fraction_value_s2  <= ok ? frac_acc_n : '0;
			exponent_value_s2  <= !ok ? '0 :
				exp_neg_n ? -$signed({1'b0, exp_acc_n}) : $signed({1'b0, exp_acc_n});
			overflow_s2        <= ok && ovf_n;
		end
	end

	assign result.valid           = valid_s2;
	assign result.valid_res       = valid_res_s2;
	assign result.base_length     = base_length_s2;
	assign result.fraction_start  = fraction_start_s2;
	assign result.fraction_length = fraction_length_s2;
	assign result.exponent_start  = exponent_start_s2;
	assign result.exponent_length = exponent_length_s2;
	assign result.base_value      = base_value_s2;
	assign result.fraction_value  = fraction_value_s2;
	assign result.exponent_value  = exponent_value_s2;
	assign result.overflow        = overflow_s2;

endmodule
